// ----- sv/positional_array_insert_delete_core_defines.svh -----
// Assertion macros shared by the positional list core.
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH

// Checks a condition at every rising clock edge outside reset.
`define PIA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle, outside reset.
`define PIA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Checks a condition in the cycle that follows a reset cycle.
`define PIA_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

// ----- sv/pia_pkg.sv -----
// Types and constants shared by the positional list core modules.
`default_nettype none

package pia_pkg;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LIST   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_INSERT,
      OP_DELETE,
      OP_LIST
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } queue_entry_type;

endpackage

`default_nettype wire

// ----- sv/pia_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pia_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/pia_front.sv -----
// Request intake: decodes the mode, drops unused modes and queues requests.
`default_nettype none

module pia_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [pia_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [pia_pkg::POS_W-1:0]        req_position,
   input  wire logic signed [pia_pkg::DATA_W-1:0] req_value,
   output logic                                  q_valid,
   input  wire logic                             q_pop,
   output pia_pkg::queue_entry_type              q_entry
);

   import pia_pkg::*;

   queue_entry_type entries_ff [2];
   logic            wr_ptr_ff;
   logic            wr_ptr_in;
   logic            rd_ptr_ff;
   logic            rd_ptr_in;
   logic [1:0]      fill_ff;
   logic [1:0]      fill_in;
   logic            mode_ok;
   op_type          op_dec;
   logic            push;
   logic            pop;

   always_comb begin
      mode_ok = 1'b1;
      op_dec  = OP_CLEAR;
      case (req_mode)
         MODE_CLEAR:  op_dec = OP_CLEAR;
         MODE_APPEND: op_dec = OP_APPEND;
         MODE_INSERT: op_dec = OP_INSERT;
         MODE_DELETE: op_dec = OP_DELETE;
         MODE_LIST:   op_dec = OP_LIST;
         default:     mode_ok = 1'b0;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_entry   = entries_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && mode_ok;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= '{op: op_dec, position: req_position, value: req_value};
      end
   end

endmodule

`default_nettype wire

// ----- sv/pia_back.sv -----
// Request engine: checks requests against the count, shifts the list in RAM, emits results.
`default_nettype none

module pia_back #(
   parameter int DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   output logic                                    q_pop,
   input  wire pia_pkg::queue_entry_type           q_entry,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [pia_pkg::DATA_W-1:0]       rsp_data,
   output logic [pia_pkg::SLOT_W-1:0]              rsp_slot,
   output logic [pia_pkg::SLOT_W-1:0]              rsp_size_now,
   output logic [pia_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                    rsp_last,
   output logic [$clog2(DEPTH+1)-1:0]              count_o
);

   import pia_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PUT,
      S_DEL_HEAD,
      S_SHIFT_DN,
      S_EMIT,
      S_LOUT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             tgt_ff, tgt_in;
   logic signed [DATA_W-1:0]  val_ff, val_in;
   logic signed [DATA_W-1:0]  res_data_ff, res_data_in;
   logic [SLOT_W-1:0]         res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [SLOT_W-1:0]         rsp_size_ff, rsp_size_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      mem_wr_en;
   logic [AW-1:0]             mem_wr_addr;
   logic [DATA_W-1:0]         mem_wr_data;
   logic                      mem_rd_en;
   logic [AW-1:0]             mem_rd_addr;
   logic [DATA_W-1:0]         mem_rd_data;

   logic [CMPW-1:0]           pos_x, cnt_x, tgt_x, cur_x;
   logic [CW-1:0]             cur_p1, cur_m1, cnt_m1;
   logic                      is_full, ins_bad, del_bad, more, out_free;

   pia_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign pos_x    = CMPW'(q_entry.position);
   assign cnt_x    = CMPW'(count_ff);
   assign tgt_x    = pos_x - CMPW'(1);
   assign cur_x    = CMPW'(cur_ff);
   assign cur_p1   = cur_ff + CW'(1);
   assign cur_m1   = cur_ff - CW'(1);
   assign cnt_m1   = count_ff - CW'(1);
   assign is_full  = (cnt_x == CMPW'(DEPTH));
   assign ins_bad  = (pos_x == '0) || (pos_x > (cnt_x + CMPW'(1)));
   assign del_bad  = (pos_x == '0) || (pos_x > cnt_x);
   assign more     = (cur_p1 < count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      val_in        = val_ff;
      res_data_in   = res_data_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               res_data_in   = '0;
               res_slot_in   = '0;
               res_status_in = ST_OK;
               val_in        = q_entry.value;
               tgt_in        = tgt_x[CW-1:0];
               state_in      = S_EMIT;
               case (q_entry.op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (is_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = q_entry.value;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (is_full) begin
                        res_status_in = ST_FULL;
                     end else if (ins_bad) begin
                        res_status_in = ST_BADPOS;
                     end else if (tgt_x == cnt_x) begin
                        // Insert just past the end needs no shifting.
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = count_ff[AW-1:0];
                        mem_wr_data = q_entry.value;
                        count_in    = count_ff + CW'(1);
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cnt_m1[AW-1:0];
                        cur_in      = cnt_m1;
                        state_in    = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else if (del_bad) begin
                        res_status_in = ST_BADPOS;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = tgt_x[AW-1:0];
                        cur_in      = tgt_x[CW-1:0];
                        res_slot_in = tgt_x[SLOT_W-1:0];
                        state_in    = S_DEL_HEAD;
                     end
                  end
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = '0;
                        cur_in      = '0;
                        state_in    = S_LOUT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_p1[AW-1:0];
            mem_wr_data = mem_rd_data;
            if (cur_ff == tgt_ff) begin
               state_in = S_PUT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cur_m1[AW-1:0];
               cur_in      = cur_m1;
            end
         end
         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = tgt_ff[AW-1:0];
            mem_wr_data = val_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_EMIT;
         end
         S_DEL_HEAD, S_SHIFT_DN: begin
            if (state_ff == S_DEL_HEAD) begin
               res_data_in = mem_rd_data;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_m1[AW-1:0];
               mem_wr_data = mem_rd_data;
            end
            if (more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cur_p1[AW-1:0];
               cur_in      = cur_p1;
               state_in    = S_SHIFT_DN;
            end else begin
               count_in = cnt_m1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_size_in   = cnt_x[SLOT_W-1:0];
               rsp_status_in = res_status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LOUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = mem_rd_data;
               rsp_slot_in   = cur_x[SLOT_W-1:0];
               rsp_size_in   = cnt_x[SLOT_W-1:0];
               rsp_status_in = ST_OK;
               rsp_last_in   = !more;
               if (more) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = cur_p1[AW-1:0];
                  cur_in      = cur_p1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      val_ff        <= val_in;
      res_data_ff   <= res_data_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_size_now = rsp_size_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;
   assign count_o      = count_ff;

endmodule

`default_nettype wire

// ----- sv/positional_array_insert_delete_core.sv -----
// Top level of the positional list core: request intake, queue, list engine and RAM.
`default_nettype none

//  Channel | Direction | Handshake           | Beat contents
//  req     | in        | req_valid/req_ready | mode, position, value
//  rsp     | out       | rsp_valid/rsp_ready | data, slot, size_now, status, last
//
//  Clear, append and rejected requests pass through the emit state into the result register.
//  Insert moves each entry at or above the target up one row, then writes the value; delete
//  moves later entries down; the single RAM read port and write port move one entry a cycle.
//  A list beat leaves every cycle while rsp_ready is high, one RAM read per listed entry.
//  Reset is synchronous: it empties the list and the request queue; RAM contents are kept.
//  A two-beat queue lets requests enter while the engine is busy or the result is stalled.

`include "positional_array_insert_delete_core_defines.svh"

module positional_array_insert_delete_core #(
   parameter int DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [pia_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [pia_pkg::POS_W-1:0]          req_position,
   input  wire logic signed [pia_pkg::DATA_W-1:0]  req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [pia_pkg::DATA_W-1:0]       rsp_data,
   output logic [pia_pkg::SLOT_W-1:0]              rsp_slot,
   output logic [pia_pkg::SLOT_W-1:0]              rsp_size_now,
   output logic [pia_pkg::STATUS_W-1:0]            rsp_status,
   output logic                                    rsp_last
);

   import pia_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;
   logic [CW-1:0]   list_count;

   // The front accepts requests, decodes the mode and drops modes that do nothing.
   pia_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_entry      (q_entry)
   );

   // The back checks each request against the current count, moves entries in RAM
   // and drives the result register.
   pia_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_entry      (q_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .rsp_slot     (rsp_slot),
      .rsp_size_now (rsp_size_now),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .count_o      (list_count)
   );

   // The list never holds more entries than the RAM has rows.
   `PIA_ASSERT_ALWAYS(a_count_bound, list_count <= CW'(DEPTH), "list count above depth")

   // Every rejected or empty result is the only beat of its request.
   `PIA_ASSERT_IMPLY(a_reject_last, rsp_valid && (rsp_status != ST_OK), rsp_last, "reject not last")

   // An empty status always reports an empty list.
   `PIA_ASSERT_IMPLY(a_empty_size, rsp_valid && (rsp_status == ST_EMPTY), rsp_size_now == '0, "empty with entries")

   // No result is offered in the cycle after a reset.
   `PIA_ASSERT_AFTER_RESET(a_reset_quiet, !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire

// ----- verif/pia_list_checker.sv -----
// Watches both channels of the positional list core, predicts every result beat and compares.
`timescale 1ns / 1ps

module pia_list_checker
   import pia_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [DATA_W-1:0]   rsp_data,
   input  logic [SLOT_W-1:0]          rsp_slot,
   input  logic [SLOT_W-1:0]          rsp_size_now,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic                       rsp_last,
   output int                         fail_count,
   output int                         pending_results,
   output int                         results_checked
);

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [SLOT_W-1:0]        slot;
      logic [SLOT_W-1:0]        size_now;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } list_beat_t;

   // Shadow copy of the list and its length.
   logic signed [DATA_W-1:0] shadow_list [DEPTH];
   int                       shadow_len;
   list_beat_t               awaited_beats [$];
   int                       failures;
   int                       beats_seen;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
      failures        = 0;
      beats_seen      = 0;
      shadow_len      = 0;
   end

   task automatic queue_beat(input logic signed [DATA_W-1:0] data, input int slot,
                             input logic [STATUS_W-1:0] status, input logic last);
      list_beat_t beat;
      beat.data     = data;
      beat.slot     = SLOT_W'(slot);
      beat.size_now = SLOT_W'(shadow_len);
      beat.status   = status;
      beat.last     = last;
      awaited_beats.push_back(beat);
   endtask

   task automatic apply_list_request(input logic [MODE_W-1:0] mode, input int pos,
                                     input logic signed [DATA_W-1:0] val);
      logic signed [DATA_W-1:0] removed;
      case (mode)
         MODE_CLEAR: begin
            shadow_len = 0;
            queue_beat('0, 0, ST_OK, 1'b1);
         end
         MODE_APPEND: begin
            if (shadow_len >= DEPTH) begin
               queue_beat('0, 0, ST_FULL, 1'b1);
            end else begin
               shadow_list[shadow_len] = val;
               shadow_len++;
               queue_beat('0, 0, ST_OK, 1'b1);
            end
         end
         MODE_INSERT: begin
            if (shadow_len >= DEPTH) begin
               queue_beat('0, 0, ST_FULL, 1'b1);
            end else if (pos < 1 || pos > shadow_len + 1) begin
               queue_beat('0, 0, ST_BADPOS, 1'b1);
            end else begin
               for (int j = shadow_len; j > pos - 1; j--) shadow_list[j] = shadow_list[j-1];
               shadow_list[pos-1] = val;
               shadow_len++;
               queue_beat('0, 0, ST_OK, 1'b1);
            end
         end
         MODE_DELETE: begin
            if (shadow_len == 0) begin
               queue_beat('0, 0, ST_EMPTY, 1'b1);
            end else if (pos < 1 || pos > shadow_len) begin
               queue_beat('0, 0, ST_BADPOS, 1'b1);
            end else begin
               removed = shadow_list[pos-1];
               for (int j = pos - 1; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j+1];
               shadow_len--;
               queue_beat(removed, pos - 1, ST_OK, 1'b1);
            end
         end
         MODE_LIST: begin
            if (shadow_len == 0) begin
               queue_beat('0, 0, ST_EMPTY, 1'b1);
            end else begin
               for (int j = 0; j < shadow_len; j++)
                  queue_beat(shadow_list[j], j, ST_OK, j + 1 == shadow_len);
            end
         end
         default: begin
            // Unused mode codes leave the list alone and produce nothing.
         end
      endcase
   endtask

   always @(posedge clock) begin
      list_beat_t want;
      if (reset) begin
         shadow_len = 0;
         awaited_beats.delete();
      end else begin
         if (req_valid && req_ready)
            apply_list_request(req_mode, int'(req_position), req_value);
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (awaited_beats.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected result beat data=%0d slot=%0d size=%0d status=%0d last=%0d",
                           $realtime, rsp_data, rsp_slot, rsp_size_now, rsp_status, rsp_last);
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_data !== want.data || rsp_slot !== want.slot ||
                   rsp_size_now !== want.size_now || rsp_status !== want.status ||
                   rsp_last !== want.last) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: mismatch expected data=%0d slot=%0d size=%0d status=%0d last=%0d, got data=%0d slot=%0d size=%0d status=%0d last=%0d",
                              $realtime, want.data, want.slot, want.size_now, want.status,
                              want.last, rsp_data, rsp_slot, rsp_size_now, rsp_status,
                              rsp_last);
               end
            end
         end
      end
      fail_count      <= failures;
      pending_results <= awaited_beats.size();
      results_checked <= beats_seen;
   end

endmodule

// ----- verif/tb_positional_array_insert_delete_core.sv -----
// Stimulus and verdict for the positional list core; checking lives in pia_list_checker.
`timescale 1ns / 1ps

module tb_positional_array_insert_delete_core;
   import pia_pkg::*;

   localparam int LIST_DEPTH = 16;
   // Cycles without any beat on either channel before the run is declared hung.
   localparam int HANG_LIMIT = 5000;
   // Items per idling phase, on top of the directed opening.
   localparam int PHASE_ITEMS = 52;
   // Mode codes 5 through 7 have no meaning and must be dropped silently.
   localparam logic [MODE_W-1:0] MODE_RESERVED_LO = 3'd5;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_data;
   logic [SLOT_W-1:0]        rsp_slot;
   logic [SLOT_W-1:0]        rsp_size_now;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_last;

   int fail_count;
   int pending_results;
   int results_checked;

   // Percent chances that the sender inserts an idle cycle and that the receiver stalls.
   int sender_idle_pct;
   int receiver_stall_pct;
   // Rough length of the list as the stimulus sees it, used only to aim positions.
   int est_len;
   int shaped_items;
   int requests_sent;
   int idle_cycles;

   positional_array_insert_delete_core #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .rsp_slot     (rsp_slot),
      .rsp_size_now (rsp_size_now),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   pia_list_checker #(
      .DEPTH(LIST_DEPTH)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_slot        (rsp_slot),
      .rsp_size_now    (rsp_size_now),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver decides at each falling edge whether it takes a beat at the next rising
   // edge. It is held low through reset so nothing is consumed before the block is alive.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Watchdog: any stretch this long with no beat on either side means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("Timeout after %0d cycles without a beat", HANG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Presents one request beat and returns at the rising edge where it is accepted.
   // The sender may first insert idle cycles; while idling, valid is held low, and when
   // there is no idle cycle the next beat follows back to back with valid staying high.
   task automatic send_request(input logic [MODE_W-1:0] mode, input int pos,
                               input logic signed [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_mode     = mode;
      req_position = POS_W'(pos);
      req_value    = val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      // Track the length well enough to aim positions at the interesting range.
      case (mode)
         MODE_CLEAR:  est_len = 0;
         MODE_APPEND: if (est_len < LIST_DEPTH) est_len++;
         MODE_INSERT: if (est_len < LIST_DEPTH && pos >= 1 && pos <= est_len + 1) est_len++;
         MODE_DELETE: if (est_len > 0 && pos >= 1 && pos <= est_len) est_len--;
         default: ;
      endcase
      if (mode <= MODE_LIST) shaped_items++;
   endtask

   // Fills the list to the brim, then pushes both kinds of writes against the full list.
   task automatic fill_to_full();
      while (est_len < LIST_DEPTH) send_request(MODE_APPEND, 0, pick_value());
      send_request(MODE_APPEND, 0, pick_value());
      send_request(MODE_INSERT, $urandom_range(1, LIST_DEPTH + 1), pick_value());
   endtask

   // One random request: mostly positions that land inside the list, some anywhere in the
   // field's range, a few list dumps and clears, and the odd reserved mode code.
   task automatic random_request();
      int roll;
      int pos;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) begin
         pos = (roll < 54) ? $urandom_range(1, est_len + 1)
                           : $urandom_range(1, (est_len > 0) ? est_len : 1);
      end else begin
         pos = $urandom_range(0, 31);
      end
      if (roll < 3)
         fill_to_full();
      else if (roll < 28)
         send_request(MODE_APPEND, $urandom_range(0, 31), pick_value());
      else if (roll < 54)
         send_request(MODE_INSERT, pos, pick_value());
      else if (roll < 80)
         send_request(MODE_DELETE, pos, pick_value());
      else if (roll < 90)
         send_request(MODE_LIST, $urandom_range(0, 31), pick_value());
      else if (roll < 94)
         send_request(MODE_CLEAR, $urandom_range(0, 31), pick_value());
      else
         send_request(MODE_RESERVED_LO + 3'($urandom_range(0, 2)), $urandom_range(0, 31),
                      $urandom);
   endtask

   // Drops valid and holds the sender back until every predicted beat has come out.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_mode           = MODE_CLEAR;
      req_position       = '0;
      req_value          = '0;
      rsp_ready          = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      est_len            = 0;
      shaped_items       = 0;
      requests_sent      = 0;
      idle_cycles        = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening: empty-list cases, bad positions at both ends of the field,
      // value extremes, inserts at the head and just past the tail, deletes at the tail
      // and head, the reserved mode codes, and a clear followed by an empty dump.
      send_request(MODE_LIST, 0, '0);
      send_request(MODE_DELETE, 1, '0);
      send_request(MODE_INSERT, 0, 32'sh12345678);
      send_request(MODE_INSERT, 2, 32'sh12345678);
      send_request(MODE_INSERT, 1, 32'sh7fffffff);
      send_request(MODE_APPEND, 31, 32'sh80000000);
      send_request(MODE_APPEND, 0, '1);
      send_request(MODE_APPEND, 0, '0);
      send_request(MODE_INSERT, 31, 32'sh0badf00d);
      send_request(MODE_INSERT, 5, 32'sh55555555);
      send_request(MODE_INSERT, 1, 32'shaaaaaaaa);
      send_request(MODE_LIST, 31, '1);
      send_request(MODE_DELETE, 0, '0);
      send_request(MODE_DELETE, 31, '0);
      send_request(MODE_DELETE, 7, '0);
      send_request(MODE_DELETE, 6, '0);
      send_request(MODE_DELETE, 1, '0);
      send_request(3'd5, 3, 32'sh1);
      send_request(3'd6, 3, 32'sh1);
      send_request(3'd7, 3, 32'sh1);
      send_request(MODE_LIST, 0, '0);
      send_request(MODE_CLEAR, 0, '0);
      send_request(MODE_LIST, 0, '0);
      drain_results();

      // Four pressure phases: free flow, a lazy sender, a lazy receiver, then both.
      // Each starts with a fill to full and ends with the sender waiting for the drain.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
         endcase
         shaped_items = 0;
         fill_to_full();
         while (shaped_items < PHASE_ITEMS) random_request();
         drain_results();
      end

      // Let anything still in flight surface before the verdict.
      repeat (40) @(posedge clock);
      $display("Run covered %0d requests (directed cases plus four idle/stall mixes)",
               requests_sent);
      $display("and %0d result beats, including full, bad-position and empty rejections",
               results_checked);
      if (fail_count == 0 && pending_results == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
